### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define LSPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lsps assertion failed");

// Checked at every edge, reset included.
`define LSPS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("lsps assertion failed");

`endif

### rtl/lsps_pkg.sv
// ---------------------------------------------------------------------------
// lsps_pkg
// Types and constants shared by the LED strip pulse serializer.
// ---------------------------------------------------------------------------
`default_nettype none

package lsps_pkg;

    localparam int LED_COUNT    = 32;
    localparam int BITS_PER_LED = 24;
    localparam int LED_W        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int BIT_W        = $clog2(BITS_PER_LED);
    localparam int COLOR_W      = 24;
    localparam int TICK_W       = 6;
    localparam int GAP_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [TICK_W-1:0] BIT_PERIOD_RST = TICK_W'(30);
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = TICK_W'(17);
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = TICK_W'(9);
    localparam logic [GAP_W-1:0]  GAP_SLOTS_RST  = GAP_W'(42);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_PERIOD = 2'd0,
        CFG_ONE_HIGH   = 2'd1,
        CFG_ZERO_HIGH  = 2'd2,
        CFG_GAP_SLOTS  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET_ONE = 2'd1,
        OP_SET_ALL = 2'd2,
        OP_START   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [4:0]         led_index;
        logic [COLOR_W-1:0] grb_color;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic start_rejected;
        logic frame_done;
    } t_out_item;

    // Decoded command handed from front end to back end.
    typedef struct packed {
        t_op                op;
        logic               idx_ok;
        logic [LED_W-1:0]   led;
        logic [COLOR_W-1:0] color;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/led_strip_pulse_serializer.sv
// Throughput: one item per clock cycle, sustained, with both sides ready.
// Path: a result is offered once its transfer in has passed a queue slot,
// then the back end's result register; the back-end update of slot timing
// and stores for each popped command sets the rate.
// Reset: synchronous, active low; colour store and configuration take their
// reset values at once, no clearing pass; the frame store is not reset.
// ---------------------------------------------------------------------------
// led_strip_pulse_serializer
// One-wire LED strip driver: colour stores, bit-slot timing, latch gap.
// ---------------------------------------------------------------------------
`default_nettype none

module led_strip_pulse_serializer (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // command channel
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  lsps_pkg::t_in_item             i_in_data,
    // result channel, one result per command
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output lsps_pkg::t_out_item            o_out_data,
    // configuration write port
    input  wire                            i_cfg_we,
    input  wire [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [lsps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsps_pkg::*;

    // Front end decodes each transfer in and pushes it into a two-entry
    // queue; the back end pops one entry a cycle unless the result side
    // holds it off, so the input stalls only once both entries are waiting
    // on a blocked result.
    logic front_push;
    t_cmd front_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    lsps_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (front_push),
        .o_cmd      (front_cmd),
        .i_q_full   (q_full)
    );

    lsps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    // Back end executes commands in order: colour writes, frame snapshot,
    // and tick-driven walk over LEDs (MSB first within each 24-bit word)
    // followed by the all-low latch gap. Its result register is reloaded
    // in the same cycle it is taken, so the result side streams too.
    lsps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### rtl/lsps_front.sv
// ---------------------------------------------------------------------------
// lsps_front
// Input side: takes transfers and decodes them into commands.
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_front (
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  lsps_pkg::t_in_item  i_in_data,
    output logic                o_push,
    output lsps_pkg::t_cmd      o_cmd,
    input  wire                 i_q_full
);
    import lsps_pkg::*;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.op     = t_op'(i_in_data.opcode);
        // indices past the strip end are flagged here; the back end drops their writes
        o_cmd.idx_ok = ({1'b0, i_in_data.led_index} < 6'(LED_COUNT));
        o_cmd.led    = i_in_data.led_index[LED_W-1:0];
        o_cmd.color  = i_in_data.grb_color;
    end

endmodule

`default_nettype wire

### rtl/lsps_queue.sv
// ---------------------------------------------------------------------------
// lsps_queue
// Two-entry command queue between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  lsps_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  wire             i_pop,
    output lsps_pkg::t_cmd  o_cmd
);
    import lsps_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

endmodule

`default_nettype wire

### rtl/lsps_back.sv
// ---------------------------------------------------------------------------
// lsps_back
// Back end: colour and frame stores, slot timing, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lsps_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [lsps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                            i_q_valid,
    output logic                           o_q_pop,
    input  lsps_pkg::t_cmd                 i_cmd,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output lsps_pkg::t_out_item            o_out_data
);
    import lsps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DATA,
        S_GAP
    } t_state;

    localparam logic [LED_W-1:0] LAST_LED = LED_W'(LED_COUNT - 1);
    localparam logic [BIT_W-1:0] TOP_BIT  = BIT_W'(BITS_PER_LED - 1);

    logic [TICK_W-1:0] r_bit_period, r_one_high, r_zero_high;
    logic [GAP_W-1:0]  r_gap_slots;

    logic [COLOR_W-1:0] r_color [LED_COUNT];
    logic [COLOR_W-1:0] r_frame [LED_COUNT];

    t_state            r_state,  n_state;
    logic [TICK_W-1:0] r_tick,   n_tick;
    logic [LED_W-1:0]  r_led,    n_led;
    logic [BIT_W-1:0]  r_bit,    n_bit;
    logic [GAP_W-1:0]  r_gap,    n_gap;
    logic              r_out_valid;
    t_out_item         r_out,    n_out;

    logic              pop;
    logic              level;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] period_m1;
    logic              slot_end;

    assign pop         = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
            r_one_high   <= ONE_HIGH_RST;
            r_zero_high  <= ZERO_HIGH_RST;
            r_gap_slots  <= GAP_SLOTS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BIT_PERIOD: r_bit_period <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_HIGH:   r_one_high   <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_HIGH:  r_zero_high  <= i_cfg_data[TICK_W-1:0];
                CFG_GAP_SLOTS:  r_gap_slots  <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // line level at the current position, before the command acts
    always_comb begin
        high_ticks = r_frame[r_led][r_bit] ? r_one_high : r_zero_high;
        level      = (r_state == S_DATA) && (r_tick < high_ticks);
        period_m1  = (r_bit_period == '0) ? '0 : r_bit_period - TICK_W'(1);
        slot_end   = (r_tick >= period_m1);
    end

    always_comb begin
        n_state = r_state;
        n_tick  = r_tick;
        n_led   = r_led;
        n_bit   = r_bit;
        n_gap   = r_gap;
        n_out.line_level     = level;
        n_out.start_rejected = 1'b0;
        n_out.frame_done     = 1'b0;
        case (i_cmd.op)
            OP_TICK: begin
                if (r_state != S_IDLE) begin
                    if (!slot_end) begin
                        n_tick = r_tick + TICK_W'(1);
                    end else begin
                        n_tick = '0;
                        if (r_state == S_DATA) begin
                            if (r_bit != '0) begin
                                n_bit = r_bit - BIT_W'(1);
                            end else if (r_led != LAST_LED) begin
                                n_led = r_led + LED_W'(1);
                                n_bit = TOP_BIT;
                            end else if (r_gap_slots == '0) begin
                                n_state          = S_IDLE;
                                n_out.frame_done = 1'b1;
                            end else begin
                                n_state = S_GAP;
                                n_gap   = '0;
                            end
                        end else begin
                            if (({1'b0, r_gap} + 9'd1) >= {1'b0, r_gap_slots}) begin
                                n_state          = S_IDLE;
                                n_out.frame_done = 1'b1;
                            end else begin
                                n_gap = r_gap + GAP_W'(1);
                            end
                        end
                    end
                end
            end
            OP_START: begin
                if (r_state != S_IDLE) begin
                    n_out.start_rejected = 1'b1;
                end else begin
                    n_state = S_DATA;
                    n_tick  = '0;
                    n_led   = '0;
                    n_bit   = TOP_BIT;
                    n_gap   = '0;
                end
            end
            default: ;
        endcase
        n_out.busy_res = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_led       <= '0;
            r_bit       <= TOP_BIT;
            r_gap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_state <= n_state;
                r_tick  <= n_tick;
                r_led   <= n_led;
                r_bit   <= n_bit;
                r_gap   <= n_gap;
                r_out   <= n_out;
            end
            if (pop)              r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // colour store: cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) r_color[i] <= '0;
        end else if (pop) begin
            if (i_cmd.op == OP_SET_ONE && i_cmd.idx_ok) begin
                r_color[i_cmd.led] <= i_cmd.color;
            end else if (i_cmd.op == OP_SET_ALL) begin
                for (int i = 0; i < LED_COUNT; i++) r_color[i] <= i_cmd.color;
            end
        end
    end

    // frame store: snapshot taken on an accepted start
    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.op == OP_START && r_state == S_IDLE) begin
            for (int i = 0; i < LED_COUNT; i++) r_frame[i] <= r_color[i];
        end
    end

endmodule

`default_nettype wire

### rtl/lsps_checker.sv
// ---------------------------------------------------------------------------
// lsps_checker
// Port-level checks on the serializer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsps_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input lsps_pkg::t_out_item o_out_data
);
    import lsps_pkg::*;

    // a pending result holds until taken
    `LSPS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
    // nothing offered right after reset
    `LSPS_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_out_valid)
    // frame end leaves the block idle
    `LSPS_ASSERT(a_done_idle, o_out_valid && o_out_data.frame_done |-> !o_out_data.busy_res)
    // a start is refused only while a frame runs, never on a frame-end tick
    `LSPS_ASSERT(a_rej_busy, o_out_valid && o_out_data.start_rejected |-> o_out_data.busy_res && !o_out_data.frame_done)

endmodule

bind led_strip_pulse_serializer lsps_checker u_lsps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

### tb/tb_led_strip_pulse_serializer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_led_strip_pulse_serializer
// Self-checking bench for the LED strip pulse serializer. Commands are fed
// through the valid/ready channel with random gaps; every result transfer is
// checked against a cycle-free model of the colour stores, slot timing and
// latch gap. Timing registers are rewritten between phases, often mid-frame.
// ---------------------------------------------------------------------------

module tb_led_strip_pulse_serializer;

    import lsps_pkg::*;

    localparam int DATA_SLOTS   = LED_COUNT * BITS_PER_LED;
    localparam int RANDOM_CMDS  = 1500;  // rough size of the random part
    localparam int MAX_PHASES   = 80;
    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer on either side

    // -----------------------------------------------------------------------
    // Clock, reset and DUT connections; every input known from time zero
    // -----------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_data;

    always #10 clk = ~clk;

    led_strip_pulse_serializer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // -----------------------------------------------------------------------
    // Strip model state: stores, timing registers and frame position
    // -----------------------------------------------------------------------
    logic [COLOR_W-1:0] color_mem [LED_COUNT];
    logic [COLOR_W-1:0] frame_mem [LED_COUNT];
    logic               busy;
    logic [TICK_W-1:0]  tick_cnt;
    logic [9:0]         slot_cnt;
    logic [TICK_W-1:0]  bit_period;
    logic [TICK_W-1:0]  one_high;
    logic [TICK_W-1:0]  zero_high;
    logic [GAP_W-1:0]   gap_slots;

    t_in_item  cmd_backlog [$];  // commands waiting to be driven
    t_out_item due_status  [$];  // line/flag values owed by the DUT, oldest first

    int mismatches    = 0;
    int results_seen  = 0;
    int cmds_queued   = 0;
    int quiet_cycles  = 0;
    int send_pause    = 0;
    int sink_pause    = 0;
    bit src_steady    = 1'b0;
    bit sink_steady   = 1'b0;

    // One command applied to the strip model. The level reported is the one
    // the line holds at the position before the command; busy is after it.
    function automatic t_out_item advance_strip(t_in_item cmd);
        t_out_item         res;
        int unsigned       per;
        int unsigned       total;
        int unsigned       led;
        int unsigned       bitpos;
        logic [TICK_W-1:0] hi;
        res = '0;
        if (busy && slot_cnt < DATA_SLOTS) begin
            led    = slot_cnt / BITS_PER_LED;
            bitpos = BITS_PER_LED - 1 - (slot_cnt % BITS_PER_LED);
            hi     = frame_mem[led][bitpos] ? one_high : zero_high;
            res.line_level = (tick_cnt < hi);
        end
        case (t_op'(cmd.opcode))
            OP_TICK: begin
                if (busy) begin
                    // zero period behaves as one tick per slot
                    per   = (bit_period == 0) ? 1 : bit_period;
                    total = DATA_SLOTS + gap_slots;
                    // a count left over from a longer period ends the slot now
                    if (tick_cnt + 1 >= per) begin
                        tick_cnt = '0;
                        slot_cnt = slot_cnt + 1'b1;
                        if (slot_cnt >= total) begin
                            busy           = 1'b0;
                            slot_cnt       = '0;
                            res.frame_done = 1'b1;
                        end
                    end else begin
                        tick_cnt = tick_cnt + 1'b1;
                    end
                end
            end
            OP_SET_ONE: begin
                if (cmd.led_index < LED_COUNT) color_mem[cmd.led_index] = cmd.grb_color;
            end
            OP_SET_ALL: begin
                foreach (color_mem[i]) color_mem[i] = cmd.grb_color;
            end
            default: begin
                if (busy) begin
                    res.start_rejected = 1'b1;
                end else begin
                    frame_mem = color_mem;
                    busy      = 1'b1;
                    tick_cnt  = '0;
                    slot_cnt  = '0;
                end
            end
        endcase
        res.busy_res = busy;
        return res;
    endfunction

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int pick_pause(bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return COLOR_W'($urandom);
    endfunction

    // Mostly ticks so frames get through, with colour writes and starts
    // scattered in; busy-time starts and writes fall out naturally.
    function automatic t_in_item random_cmd();
        t_in_item    c;
        int unsigned r;
        r           = $urandom_range(0, 99);
        c.led_index = 5'($urandom);
        c.grb_color = pick_color();
        if (r < 78)      c.opcode = OP_TICK;
        else if (r < 87) c.opcode = OP_SET_ONE;
        else if (r < 91) c.opcode = OP_SET_ALL;
        else             c.opcode = OP_START;
        return c;
    endfunction

    function automatic logic [TICK_W-1:0] pick_high(logic [TICK_W-1:0] per);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return TICK_W'($urandom_range(0, per + 1));
    endfunction

    task automatic queue_cmd(t_op op, int unsigned idx, logic [COLOR_W-1:0] color);
        t_in_item c;
        c.opcode    = op;
        c.led_index = 5'(idx);
        c.grb_color = color;
        cmd_backlog.push_back(c);
    endtask

    // Returns at a falling edge once no command is pending or in flight and
    // every owed result has come back.
    task automatic wait_idle();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || in_valid || due_status.size() != 0)
            @(negedge clk);
    endtask

    // One register write; the model copy changes at the same point in the
    // command sequence. Unused upper data bits are driven at random.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] word;
        word = val;
        if (idx != CFG_GAP_SLOTS) word[CFG_DATA_W-1:TICK_W] = 2'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        case (idx)
            CFG_BIT_PERIOD: bit_period = word[TICK_W-1:0];
            CFG_ONE_HIGH:   one_high   = word[TICK_W-1:0];
            CFG_ZERO_HIGH:  zero_high  = word[TICK_W-1:0];
            default:        gap_slots  = word[GAP_W-1:0];
        endcase
    endtask

    task automatic write_timing(logic [TICK_W-1:0] per, logic [TICK_W-1:0] one,
                                logic [TICK_W-1:0] zero, logic [GAP_W-1:0] gap);
        write_reg(CFG_BIT_PERIOD, CFG_DATA_W'(per));
        write_reg(CFG_ONE_HIGH, CFG_DATA_W'(one));
        write_reg(CFG_ZERO_HIGH, CFG_DATA_W'(zero));
        write_reg(CFG_GAP_SLOTS, CFG_DATA_W'(gap));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Command driver: one transfer per handshake, payload held while stalled
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                due_status.push_back(advance_strip(in_data));
            end
            if (in_valid && !in_ready) begin
                // stalled: keep valid and payload as they are
            end else if (send_pause > 0) begin
                send_pause--;
                in_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                in_data  <= cmd_backlog.pop_front();
                in_valid <= 1'b1;
                send_pause = pick_pause(src_steady);
                if ($urandom_range(0, 249) == 0) src_steady = !src_steady;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor: checks each result transfer, drives random back-pressure
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (due_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d with nothing outstanding: lvl %b busy %b rej %b done %b",
                                 results_seen, out_data.line_level, out_data.busy_res,
                                 out_data.start_rejected, out_data.frame_done);
                end else begin
                    want = due_status.pop_front();
                    if (out_data.line_level !== want.line_level ||
                        out_data.busy_res !== want.busy_res ||
                        out_data.start_rejected !== want.start_rejected ||
                        out_data.frame_done !== want.frame_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected lvl %b busy %b rej %b done %b, got lvl %b busy %b rej %b done %b",
                                     results_seen, want.line_level, want.busy_res,
                                     want.start_rejected, want.frame_done,
                                     out_data.line_level, out_data.busy_res,
                                     out_data.start_rejected, out_data.frame_done);
                    end
                end
                results_seen++;
            end
            if (sink_pause > 0) begin
                sink_pause--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                sink_pause = pick_pause(sink_steady);
                if ($urandom_range(0, 299) == 0) sink_steady = !sink_steady;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_led_strip_pulse_serializer: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus sequence
    // -----------------------------------------------------------------------
    initial begin
        int phases;
        logic [TICK_W-1:0] per;
        logic [GAP_W-1:0]  gap;
        int unsigned       r;
        int unsigned       n;

        // model reset values
        foreach (color_mem[i]) color_mem[i] = '0;
        foreach (frame_mem[i]) frame_mem[i] = '0;
        busy       = 1'b0;
        tick_cnt   = '0;
        slot_cnt   = '0;
        bit_period = BIT_PERIOD_RST;
        one_high   = ONE_HIGH_RST;
        zero_high  = ZERO_HIGH_RST;
        gap_slots  = GAP_SLOTS_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle tick, field extremes, busy-time start and writes
        queue_cmd(OP_TICK, 0, '0);               // idle tick, line low
        queue_cmd(OP_SET_ONE, 31, '1);
        queue_cmd(OP_SET_ALL, 0, 24'hA5C33C);
        queue_cmd(OP_SET_ONE, 0, 24'hFFFFFF);
        queue_cmd(OP_SET_ONE, 31, 24'h000000);
        queue_cmd(OP_SET_ONE, 1, 24'h800001);
        queue_cmd(OP_START, 0, '0);              // frame starts
        queue_cmd(OP_START, 31, '1);             // start while busy: flagged
        repeat (3) queue_cmd(OP_TICK, 31, '1);
        queue_cmd(OP_SET_ONE, 0, 24'h000000);    // colour store only
        queue_cmd(OP_SET_ALL, 0, 24'h123456);
        repeat (2) queue_cmd(OP_TICK, 0, '0);
        wait_idle();

        // Zero period, full one-high and zero zero-high times, changed mid-frame
        write_timing('0, '1, '0, '0);
        repeat (6) queue_cmd(OP_TICK, 0, '0);
        queue_cmd(OP_SET_ONE, 2, 24'h0F0F0F);
        repeat (4) queue_cmd(OP_TICK, 0, '0);
        wait_idle();

        // Random phases; each one rewrites the timing, usually mid-frame
        phases = 0;
        while (cmds_queued < RANDOM_CMDS && phases < MAX_PHASES) begin
            r = $urandom_range(0, 9);
            if (r == 0)      per = '0;
            else if (r == 1) per = '1;
            else             per = TICK_W'($urandom_range(1, 3));
            r = $urandom_range(0, 5);
            if (r == 0)      gap = '0;
            else if (r == 1) gap = '1;
            else             gap = GAP_W'($urandom_range(0, 6));
            write_timing(per, pick_high(per), pick_high(per), gap);

            n = $urandom_range(150, 600);
            repeat (n) cmd_backlog.push_back(random_cmd());
            cmds_queued += n;
            phases++;
            wait_idle();
        end

        // drain margin beyond the result path through queue and result register
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_status.size() == 0) begin
            $display("tb_led_strip_pulse_serializer: clean");
        end else begin
            $display("tb_led_strip_pulse_serializer: errors");
        end
        $finish;
    end

endmodule
